// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define CPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Clocked property, checked through reset as well.
`define CPS_ASSERT_ANY(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== rtl/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Types, widths and region codes for the closest-point-on-segment pipeline.
// ----------------------------------------------------------------------------
package cps_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROJ_W  = 2 * DIFF_W + 1;
  localparam int LEN_W   = 2 * DIFF_W;
  localparam int NUM_W   = DIFF_W + LEN_W + 1;
  localparam int DEN_W   = LEN_W + 1;
  localparam int QUO_W   = DIFF_W;

  localparam logic [1:0] REGION_START  = 2'd0;
  localparam logic [1:0] REGION_END    = 2'd1;
  localparam logic [1:0] REGION_INSIDE = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
  } cps_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] near_x;
    logic [COORD_W-1:0] near_y;
    logic [1:0]         region;
  } cps_out_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         region;
    logic [COORD_W-1:0] ax;
    logic [COORD_W-1:0] ay;
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic               negx;
    logic               negy;
    logic [NUM_W-1:0]   remx;
    logic [NUM_W-1:0]   remy;
    logic [DEN_W-1:0]   den;
    logic [QUO_W-1:0]   qx;
    logic [QUO_W-1:0]   qy;
  } cps_pipe_t;

endpackage

// ===== rtl/cps_div_cell.sv =====
// ----------------------------------------------------------------------------
// cps_div_cell
// One restoring-division cell: resolves one quotient bit for both axes.
// ----------------------------------------------------------------------------
module cps_div_cell #(
  parameter int BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cps_pkg::cps_pipe_t pipe_in,
  output cps_pkg::cps_pipe_t pipe_out
);
  import cps_pkg::*;

  localparam int EXT_W = NUM_W + QUO_W;

  cps_pipe_t         pipe_r;
  cps_pipe_t         pipe_nxt;
  logic [EXT_W-1:0]  shifted;

  assign shifted = EXT_W'(pipe_in.den) << BIT;

  always_comb begin
    pipe_nxt = pipe_in;
    if (EXT_W'(pipe_in.remx) >= shifted) begin
      pipe_nxt.remx    = pipe_in.remx - shifted[NUM_W-1:0];
      pipe_nxt.qx[BIT] = 1'b1;
    end
    if (EXT_W'(pipe_in.remy) >= shifted) begin
      pipe_nxt.remy    = pipe_in.remy - shifted[NUM_W-1:0];
      pipe_nxt.qy[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_r.valid <= 1'b0;
    end else begin
      pipe_r <= pipe_nxt;
    end
  end

  assign pipe_out = pipe_r;

endmodule

// ===== rtl/closest_point_on_segment.sv =====
// ----------------------------------------------------------------------------
// closest_point_on_segment
// Nearest point on segment start-end to a query point, with region code.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_data and raise start; the beat is taken at any edge with start
//   high and busy low. busy stays low, so one beat may enter every cycle.
//   Each result appears on out_data for one cycle with out_valid high, in
//   input order. Throughput is one beat per cycle.
//   A beat passes through four front stages (differences, products, sums,
//   region and numerator), one division cell per quotient bit, and the
//   output register.
//   A synchronous reset (rst_n low) drops every beat in flight.
//   The receiver cannot stall; results must be taken when shown.
// ----------------------------------------------------------------------------
module closest_point_on_segment (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cps_pkg::cps_in_t  in_data,
  output logic              out_valid,
  output cps_pkg::cps_out_t out_data
);
  import cps_pkg::*;

  localparam int W = COORD_W;

  // stage 1
  logic                     v1_r;
  logic [W-1:0]             ax1_r, ay1_r, bx1_r, by1_r;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r, ux1_r, uy1_r;
  // stage 2
  logic                     v2_r;
  logic [W-1:0]             ax2_r, ay2_r, bx2_r, by2_r;
  logic signed [DIFF_W-1:0] dx2_r, dy2_r;
  logic signed [LEN_W-1:0]  pxx2_r, pyy2_r, lxx2_r, lyy2_r;
  // stage 3
  logic                     v3_r;
  logic [W-1:0]             ax3_r, ay3_r, bx3_r, by3_r;
  logic [DIFF_W-1:0]        mdx3_r, mdy3_r;
  logic                     negx3_r, negy3_r;
  logic signed [PROJ_W-1:0] proj3_r;
  logic [LEN_W-1:0]         len3_r;

  logic                     positive;
  logic                     past_end;
  cps_pipe_t                chain [QUO_W+1];
  cps_pipe_t                head_r;
  cps_pipe_t                head_nxt;
  cps_pipe_t                tail;
  cps_out_t                 out_r;
  logic                     out_valid_r;

  function automatic cps_out_t out_data_nxt(input cps_pipe_t p);
    cps_out_t o;
    o.region = p.region;
    case (p.region)
      REGION_END: begin
        o.near_x = p.bx;
        o.near_y = p.by;
      end
      REGION_INSIDE: begin
        o.near_x = p.ax + (p.negx ? W'(-p.qx) : W'(p.qx));
        o.near_y = p.ay + (p.negy ? W'(-p.qy) : W'(p.qy));
      end
      default: begin
        o.near_x = p.ax;
        o.near_y = p.ay;
      end
    endcase
    return o;
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      head_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      v1_r  <= start;
      ax1_r <= in_data.start_x;
      ay1_r <= in_data.start_y;
      bx1_r <= in_data.end_x;
      by1_r <= in_data.end_y;
      dx1_r <= $signed({in_data.end_x[W-1], in_data.end_x})
             - $signed({in_data.start_x[W-1], in_data.start_x});
      dy1_r <= $signed({in_data.end_y[W-1], in_data.end_y})
             - $signed({in_data.start_y[W-1], in_data.start_y});
      ux1_r <= $signed({in_data.point_x[W-1], in_data.point_x})
             - $signed({in_data.start_x[W-1], in_data.start_x});
      uy1_r <= $signed({in_data.point_y[W-1], in_data.point_y})
             - $signed({in_data.start_y[W-1], in_data.start_y});

      v2_r   <= v1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      bx2_r  <= bx1_r;
      by2_r  <= by1_r;
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      pxx2_r <= ux1_r * dx1_r;
      pyy2_r <= uy1_r * dy1_r;
      lxx2_r <= dx1_r * dx1_r;
      lyy2_r <= dy1_r * dy1_r;

      v3_r    <= v2_r;
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      bx3_r   <= bx2_r;
      by3_r   <= by2_r;
      negx3_r <= dx2_r[DIFF_W-1];
      negy3_r <= dy2_r[DIFF_W-1];
      mdx3_r  <= dx2_r[DIFF_W-1] ? DIFF_W'(-dx2_r) : DIFF_W'(dx2_r);
      mdy3_r  <= dy2_r[DIFF_W-1] ? DIFF_W'(-dy2_r) : DIFF_W'(dy2_r);
      proj3_r <= PROJ_W'(pxx2_r) + PROJ_W'(pyy2_r);
      len3_r  <= $unsigned(lxx2_r) + $unsigned(lyy2_r);

      head_r <= head_nxt;

      out_valid_r <= tail.valid;
      out_r       <= out_data_nxt(tail);
    end
  end

  assign positive = !proj3_r[PROJ_W-1] && (proj3_r != '0);
  assign past_end = PROJ_W'($unsigned(proj3_r)) >= PROJ_W'(len3_r);

  always_comb begin
    head_nxt.valid = v3_r;
    head_nxt.ax    = ax3_r;
    head_nxt.ay    = ay3_r;
    head_nxt.bx    = bx3_r;
    head_nxt.by    = by3_r;
    head_nxt.negx  = negx3_r;
    head_nxt.negy  = negy3_r;
    head_nxt.den   = {len3_r, 1'b0};
    head_nxt.qx    = '0;
    head_nxt.qy    = '0;
    head_nxt.remx  = '0;
    head_nxt.remy  = '0;
    if (!positive) begin
      head_nxt.region = REGION_START;
    end else if (past_end) begin
      head_nxt.region = REGION_END;
    end else begin
      head_nxt.region = REGION_INSIDE;
      head_nxt.remx   = {(DIFF_W+LEN_W)'(mdx3_r) * (DIFF_W+LEN_W)'(proj3_r[LEN_W-1:0]),
                         1'b0} + NUM_W'(len3_r);
      head_nxt.remy   = {(DIFF_W+LEN_W)'(mdy3_r) * (DIFF_W+LEN_W)'(proj3_r[LEN_W-1:0]),
                         1'b0} + NUM_W'(len3_r);
    end
  end

  assign chain[0] = head_r;

  for (genvar k = 0; k < QUO_W; k++) begin : g_cell
    cps_div_cell #(
      .BIT (QUO_W - 1 - k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .pipe_in  (chain[k]),
      .pipe_out (chain[k+1])
    );
  end

  assign tail = chain[QUO_W];

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/cps_checker.sv =====
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks of the closest-point pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cps_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input cps_pkg::cps_in_t  in_data,
  input logic              out_valid,
  input cps_pkg::cps_out_t out_data
);
  import cps_pkg::*;

  localparam int LAT = QUO_W + 5;

  logic                 at_start;
  logic [2*COORD_W-1:0] near_xy;
  logic [2*COORD_W-1:0] start_xy;

  assign at_start = out_valid && (out_data.region == REGION_START);
  assign near_xy  = {out_data.near_x, out_data.near_y};
  assign start_xy = {in_data.start_x, in_data.start_y};

  `CPS_ASSERT_ANY(a_never_busy, clk, !busy)
  `CPS_ASSERT(a_beat_out, clk, rst_n, (start && !busy) |-> ##LAT out_valid)
  `CPS_ASSERT(a_no_spurious, clk, rst_n, !start |-> ##LAT !out_valid)
  `CPS_ASSERT(a_region_code, clk, rst_n, out_valid |-> (out_data.region <= REGION_INSIDE))
  `CPS_ASSERT(a_start_point, clk, rst_n, at_start |-> (near_xy == $past(start_xy, LAT)))

endmodule

bind closest_point_on_segment cps_checker u_cps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
